@@ hdl/hcbd_pkg.sv @@
package hcbd_pkg;

  // Default width of the chunk size counter.
  localparam int SIZE_BITS_DEFAULT = 32;

  // Error codes reported with a finished result.
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_NO_EOL    = 3'd1;
  localparam logic [2:0] ERR_NO_HEX    = 3'd2;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;
  localparam logic [2:0] ERR_BAD_TERM  = 3'd5;

  // Request operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Characters that matter on the wire.
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HT    = 8'h09;
  localparam logic [7:0] CHAR_X_LO  = 8'h78;
  localparam logic [7:0] CHAR_X_UP  = 8'h58;

  // One result from the decoder core.
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       data_valid;
    logic       finished;
    logic [2:0] error_code;
  } result_t;

endpackage

@@ hdl/http_chunked_body_decoder.sv @@
// A request accepted into the input register is decoded by the core into the result register
// when it moves on; a result, if the request makes one, is then offered on out_valid.
// Throughput: one byte per cycle; the input stalls only while a result is held and
// out_stall is high.
// Reset (rst, synchronous, active high) empties both registers and returns the decoder
// to the start of a size line.
module http_chunked_body_decoder #(
  parameter int SizeBits = hcbd_pkg::SIZE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       op,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       data_valid,
  output logic       finished,
  output logic [2:0] error_code
);

  logic              in_full;
  logic              op_q;
  logic [7:0]        byte_q;
  logic              advance;
  logic              in_take;
  hcbd_pkg::result_t res;

  // The held request moves on when the output register is free or being drained.
  assign advance  = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !advance;
  assign in_take  = in_valid && !in_stall;

  hcbd_core #(
    .SizeBits(SizeBits)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .op     (op_q),
    .in_byte(byte_q),
    .res    (res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_take || (in_full && !advance);
    end
    if (in_take) begin
      op_q   <= op;
      byte_q <= in_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_byte   <= res.out_byte;
      data_valid <= res.data_valid;
      finished   <= res.finished;
      error_code <= res.error_code;
    end
  end

endmodule

@@ hdl/hcbd_core.sv @@
module hcbd_core #(
  parameter int SizeBits = hcbd_pkg::SIZE_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              op,
  input  logic [7:0]        in_byte,
  output hcbd_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_DIGITS = 3'd1,
    PH_TAIL   = 3'd2,
    PH_DATA   = 3'd3,
    PH_DCR    = 3'd4,
    PH_DLF    = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  phase_t              phase, phase_next;
  logic [SizeBits-1:0] bytes_left, bytes_left_next;
  logic                digit_seen, digit_seen_next;
  logic                cr_pending, cr_pending_next;
  logic                line_started, line_started_next;
  logic [2:0]          line_err, line_err_next;
  logic                lone_zero, lone_zero_next;

  logic       is_hex;
  logic [3:0] hex_val;
  logic       is_space;
  logic       fin;
  logic [2:0] fin_code;
  logic       data_out;

  // Classify the incoming byte.
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
    is_space = (in_byte == hcbd_pkg::CHAR_SPACE) ||
               (in_byte >= hcbd_pkg::CHAR_HT && in_byte <= hcbd_pkg::CHAR_CR);
  end

  // Next state and result for one request.
  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    digit_seen_next   = digit_seen;
    cr_pending_next   = cr_pending;
    line_started_next = line_started;
    line_err_next     = line_err;
    lone_zero_next    = lone_zero;
    fin               = 1'b0;
    fin_code          = hcbd_pkg::ERR_OK;
    data_out          = 1'b0;

    case (phase)
      PH_LEAD, PH_DIGITS, PH_TAIL: begin
        if (op == hcbd_pkg::OP_END) begin
          fin      = 1'b1;
          fin_code = line_started ? hcbd_pkg::ERR_NO_EOL : hcbd_pkg::ERR_OK;
        end else if (cr_pending && in_byte == hcbd_pkg::CHAR_LF) begin
          // End of the size line: start data or finish.
          digit_seen_next   = 1'b0;
          cr_pending_next   = 1'b0;
          line_started_next = 1'b0;
          line_err_next     = hcbd_pkg::ERR_OK;
          lone_zero_next    = 1'b0;
          if (!digit_seen) begin
            fin      = 1'b1;
            fin_code = hcbd_pkg::ERR_NO_HEX;
          end else if (line_err != hcbd_pkg::ERR_OK) begin
            fin      = 1'b1;
            fin_code = line_err;
          end else if (bytes_left == '0) begin
            fin      = 1'b1;
            fin_code = hcbd_pkg::ERR_OK;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          line_started_next = 1'b1;
          cr_pending_next   = (in_byte == hcbd_pkg::CHAR_CR);
          if (phase == PH_LEAD) begin
            if (!is_space) begin
              if (!is_hex) begin
                phase_next = PH_TAIL;
              end else begin
                phase_next      = PH_DIGITS;
                digit_seen_next = 1'b1;
                lone_zero_next  = (hex_val == 4'd0);
                bytes_left_next = SizeBits'(hex_val);
              end
            end
          end else if (phase == PH_DIGITS) begin
            if (!is_hex) begin
              if (lone_zero && (in_byte == hcbd_pkg::CHAR_X_LO ||
                                in_byte == hcbd_pkg::CHAR_X_UP)) begin
                line_err_next = hcbd_pkg::ERR_NO_HEX;
              end
              phase_next = PH_TAIL;
            end else begin
              lone_zero_next = 1'b0;
              // Shifting in a digit overflows exactly when the top nibble is set.
              if (bytes_left[SizeBits-1 -: 4] != 4'd0) begin
                line_err_next = hcbd_pkg::ERR_OVERFLOW;
                phase_next    = PH_TAIL;
              end else begin
                bytes_left_next = {bytes_left[SizeBits-5:0], hex_val};
              end
            end
          end
        end
      end
      PH_DATA: begin
        if (op == hcbd_pkg::OP_END) begin
          fin      = 1'b1;
          fin_code = hcbd_pkg::ERR_TRUNCATED;
        end else begin
          data_out        = 1'b1;
          bytes_left_next = bytes_left - SizeBits'(1);
          if (bytes_left == SizeBits'(1)) begin
            phase_next = PH_DCR;
          end
        end
      end
      PH_DCR: begin
        if (op == hcbd_pkg::OP_END || in_byte != hcbd_pkg::CHAR_CR) begin
          fin      = 1'b1;
          fin_code = hcbd_pkg::ERR_BAD_TERM;
        end else begin
          phase_next = PH_DLF;
        end
      end
      PH_DLF: begin
        if (op == hcbd_pkg::OP_END || in_byte != hcbd_pkg::CHAR_LF) begin
          fin      = 1'b1;
          fin_code = hcbd_pkg::ERR_BAD_TERM;
        end else begin
          phase_next        = PH_LEAD;
          bytes_left_next   = '0;
          digit_seen_next   = 1'b0;
          cr_pending_next   = 1'b0;
          line_started_next = 1'b0;
          line_err_next     = hcbd_pkg::ERR_OK;
          lone_zero_next    = 1'b0;
        end
      end
      default: begin
        // Finished: everything is dropped until reset.
      end
    endcase

    if (fin) begin
      phase_next = PH_DONE;
    end

    res.valid      = fin || data_out;
    res.out_byte   = data_out ? in_byte : 8'd0;
    res.data_valid = data_out;
    res.finished   = fin;
    res.error_code = fin ? fin_code : hcbd_pkg::ERR_OK;
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEAD;
      bytes_left   <= '0;
      digit_seen   <= 1'b0;
      cr_pending   <= 1'b0;
      line_started <= 1'b0;
      line_err     <= hcbd_pkg::ERR_OK;
      lone_zero    <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      digit_seen   <= digit_seen_next;
      cr_pending   <= cr_pending_next;
      line_started <= line_started_next;
      line_err     <= line_err_next;
      lone_zero    <= lone_zero_next;
    end
  end

endmodule
